FILE: hw/rtl/fbmw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbmw_pkg;

  // Inode pointer slots
  localparam int unsigned NumSlots    = 15;
  localparam int unsigned FirstSingle = 12;
  localparam int unsigned SlotDouble  = 13;
  localparam int unsigned SlotTriple  = 14;
  localparam int unsigned SlotW       = 4;

  // Field widths
  localparam int unsigned PtrW   = 32;
  localparam int unsigned OffW   = 34;
  localparam int unsigned WordW  = 11;
  localparam int unsigned DepthW = 2;
  localparam int unsigned LbsW   = 2;

  // log2 of pointers per block is 8 + clamped block size code
  localparam int unsigned LogKBase      = 8;
  localparam int unsigned MaxLogBlockDef = 3;

  // Stream payload widths (byte aligned)
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 80;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_XLATE = 2'd1,
    OP_RESP  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_MAPPED = 2'd1,
    KIND_HOLE   = 2'd2
  } kind_e;

endpackage

`default_nettype wire

FILE: hw/rtl/file_block_map_walker.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted request passes through the item registers and then the output register.
// Throughput: one request per cycle unless stalled; the pointer memory is read once
// on acceptance and the walk state is updated in the following stage, so nothing
// waits between items. Reset clears the walk state, the block size register, the output
// valid and the per-slot valid bits, so every inode pointer reads as zero until loaded.
module file_block_map_walker
  import fbmw_pkg::*;
#(
  parameter int unsigned MaxLogBlock = MaxLogBlockDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration: log_block_size
  input  wire logic                cfg_we_i,
  input  wire logic [LbsW-1:0]     cfg_wdata_i,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: slot[3:0], pointer_value[35:4], file_block[69:36], read_word[101:70]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // tuser: op[1:0]
  input  wire logic [1:0]          s_axis_tuser,
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: req_block[31:0], req_word[42:32], phys_block[74:43], depth_used[76:75]
  output logic [OutDataW-1:0]      m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]               m_axis_tuser
);

  localparam int unsigned LkW = $clog2(LogKBase + MaxLogBlock + 1);
  localparam int unsigned ShW = $clog2(3 * (LogKBase + MaxLogBlock) + 1);

  // Input field unpacking
  logic [SlotW-1:0] in_slot;
  logic [PtrW-1:0]  in_ptr;
  logic [OffW-1:0]  in_fblock;
  logic [PtrW-1:0]  in_rword;

  assign in_slot   = s_axis_tdata[3:0];
  assign in_ptr    = s_axis_tdata[35:4];
  assign in_fblock = s_axis_tdata[69:36];
  assign in_rword  = s_axis_tdata[101:70];

  // Block size register and clamped log2 of pointers per block
  logic [LbsW-1:0] lbs_q;
  logic [LkW-1:0]  lk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lbs_q <= '0;
    end else if (cfg_we_i) begin
      lbs_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (int'(lbs_q) > int'(MaxLogBlock)) begin
      lk = LkW'(LogKBase + MaxLogBlock);
    end else begin
      lk = LkW'(LogKBase) + LkW'(lbs_q);
    end
  end

  // Handshake
  logic in_acc;
  logic s1_valid_q;
  logic s1_adv;
  logic out_valid_q;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Range decode of the file block: direct slot or level count and tree offset
  logic [OffW-1:0]  k_one, k_two, off_a, off_b, off_c, tri_mask;
  logic [ShW-1:0]   lk2, lk3;
  logic [DepthW-1:0] dec_levels;
  logic [OffW-1:0]  dec_off;
  logic [SlotW-1:0] rd_addr;

  always_comb begin
    lk2      = ShW'(lk) + ShW'(lk);
    lk3      = lk2 + ShW'(lk);
    k_one    = OffW'(1) << lk;
    k_two    = OffW'(1) << lk2;
    tri_mask = ~({OffW{1'b1}} << lk3);
    off_a    = in_fblock - OffW'(FirstSingle);
    off_b    = off_a - k_one;
    off_c    = (off_b - k_two) & tri_mask;
    if (in_fblock < OffW'(FirstSingle)) begin
      dec_levels = 2'd0;
      dec_off    = '0;
      rd_addr    = in_fblock[SlotW-1:0];
    end else if ((off_a >> lk) == '0) begin
      dec_levels = 2'd1;
      dec_off    = off_a;
      rd_addr    = SlotW'(FirstSingle);
    end else if ((off_b >> lk2) == '0) begin
      dec_levels = 2'd2;
      dec_off    = off_b;
      rd_addr    = SlotW'(SlotDouble);
    end else begin
      dec_levels = 2'd3;
      dec_off    = off_c;
      rd_addr    = SlotW'(SlotTriple);
    end
  end

  // Inode pointer memory, written and read on acceptance
  logic [PtrW-1:0]     ptr_mem [NumSlots];
  logic [NumSlots-1:0] ptr_vld_q;
  logic [PtrW-1:0]     rd_data_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == OP_LOAD && in_slot < SlotW'(NumSlots)) begin
      ptr_mem[in_slot] <= in_ptr;
    end
    if (in_acc && s_axis_tuser == OP_XLATE && rd_addr < SlotW'(NumSlots)) begin
      rd_data_q <= ptr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else if (in_acc) begin
      if (s_axis_tuser == OP_LOAD && in_slot < SlotW'(NumSlots)) begin
        ptr_vld_q[in_slot] <= 1'b1;
      end
      if (s_axis_tuser == OP_XLATE) begin
        rd_vld_q <= ptr_vld_q[rd_addr];
      end
    end
  end

  // Stage 1 item registers
  logic [1:0]        s1_op_q;
  logic [DepthW-1:0] s1_levels_q;
  logic [OffW-1:0]   s1_off_q;
  logic [PtrW-1:0]   s1_rword_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= s_axis_tuser;
      s1_levels_q <= dec_levels;
      s1_off_q    <= dec_off;
      s1_rword_q  <= in_rword;
    end
  end

  // Walk state
  logic              busy_q, busy_d;
  logic [DepthW-1:0] lvl_left_q, lvl_left_d;
  logic [OffW-1:0]   woff_q, woff_d;
  logic [DepthW-1:0] wdepth_q, wdepth_d;

  // Stage 1 evaluation
  logic [PtrW-1:0]   root;
  logic [OffW-1:0]   idx_off;
  logic [DepthW-1:0] idx_lvl;
  logic [ShW-1:0]    idx_sh;
  logic [OffW-1:0]   idx_full;
  logic [WordW-1:0]  idx_word;
  logic              res_vld;
  kind_e             res_kind;
  logic [PtrW-1:0]   res_rblk;
  logic [WordW-1:0]  res_rword;
  logic [PtrW-1:0]   res_phys;
  logic [DepthW-1:0] res_depth;

  assign root = rd_vld_q ? rd_data_q : '0;

  // Word index: digit of the tree offset for the given level
  always_comb begin
    priority case (idx_lvl)
      2'd3:    idx_sh = lk2;
      2'd2:    idx_sh = ShW'(lk);
      default: idx_sh = '0;
    endcase
    idx_full = (idx_off >> idx_sh) & ~({OffW{1'b1}} << lk);
    idx_word = idx_full[WordW-1:0];
  end

  always_comb begin
    busy_d     = busy_q;
    lvl_left_d = lvl_left_q;
    woff_d     = woff_q;
    wdepth_d   = wdepth_q;
    res_vld    = 1'b0;
    res_kind   = KIND_HOLE;
    res_rblk   = '0;
    res_rword  = '0;
    res_phys   = '0;
    res_depth  = '0;
    idx_off    = s1_off_q;
    idx_lvl    = s1_levels_q;
    unique case (s1_op_q)
      OP_XLATE: begin
        res_vld    = 1'b1;
        busy_d     = 1'b0;
        lvl_left_d = '0;
        wdepth_d   = s1_levels_q;
        res_depth  = s1_levels_q;
        if (s1_levels_q == '0) begin
          if (root != '0) begin
            res_kind = KIND_MAPPED;
            res_phys = root;
          end
        end else begin
          woff_d = s1_off_q;
          if (root != '0) begin
            busy_d     = 1'b1;
            lvl_left_d = s1_levels_q;
            res_kind   = KIND_READ;
            res_rblk   = root;
            res_rword  = idx_word;
          end
        end
      end
      OP_RESP: begin
        idx_off   = woff_q;
        idx_lvl   = lvl_left_q - 2'd1;
        res_depth = wdepth_q;
        if (busy_q && lvl_left_q != '0) begin
          res_vld = 1'b1;
          if (s1_rword_q == '0) begin
            busy_d     = 1'b0;
            lvl_left_d = '0;
          end else if (lvl_left_q == 2'd1) begin
            busy_d     = 1'b0;
            lvl_left_d = '0;
            res_kind   = KIND_MAPPED;
            res_phys   = s1_rword_q;
          end else begin
            lvl_left_d = lvl_left_q - 2'd1;
            res_kind   = KIND_READ;
            res_rblk   = s1_rword_q;
            res_rword  = idx_word;
          end
        end
      end
      default: begin
        // loads and unused codes leave no result
      end
    endcase
  end

  logic s1_fire;
  assign s1_fire = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      lvl_left_q <= '0;
      woff_q     <= '0;
      wdepth_q   <= '0;
    end else if (s1_fire) begin
      busy_q     <= busy_d;
      lvl_left_q <= lvl_left_d;
      woff_q     <= woff_d;
      wdepth_q   <= wdepth_d;
    end
  end

  // Output register
  logic [OutDataW-1:0] out_data_q;
  logic [1:0]          out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q && res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res_vld) begin
      out_kind_q <= res_kind;
      out_data_q <= {3'b000, res_depth, res_phys, res_rword, res_rblk};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

`default_nettype wire
